@@ hdl/kmp_pkg.sv @@
`timescale 1ns / 1ps

package kmp_pkg;

  // fixed widths of the item fields
  localparam int PRICE_W  = 16;
  localparam int BAL_W    = 32;
  localparam int PROFIT_W = 31;
  localparam int K_W      = 5;

  // one beat travelling down the row of cells
  typedef struct packed {
    logic                    valid;
    logic                    first;
    logic                    last;
    logic [PRICE_W-1:0]      price;
    logic signed [BAL_W-1:0] prev_sold;
    logic [PROFIT_W-1:0]     best;
  } beat_t;

  // clip a 33-bit signed sum to the 32-bit signed range
  function automatic logic signed [BAL_W-1:0] sat32(input logic signed [BAL_W:0] v);
    logic signed [BAL_W-1:0] r;
    if (v[BAL_W] != v[BAL_W-1]) begin
      r = v[BAL_W] ? {1'b1, {(BAL_W-1){1'b0}}} : {1'b0, {(BAL_W-1){1'b1}}};
    end else begin
      r = v[BAL_W-1:0];
    end
    return r;
  endfunction

endpackage

@@ hdl/kmp_cell.sv @@
`timescale 1ns / 1ps

module kmp_cell #(
  parameter int IDX = 0
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      adv_i,
  input  logic [kmp_pkg::K_W-1:0]   k_i,
  input  kmp_pkg::beat_t            beat_i,
  output kmp_pkg::beat_t            beat_o
);
  import kmp_pkg::*;

  logic signed [BAL_W-1:0] hold_q, hold_d;
  logic signed [BAL_W-1:0] sold_q, sold_d;
  beat_t                   beat_q, beat_d;

  logic signed [BAL_W:0]   price_x;
  logic signed [BAL_W-1:0] h_new, h_max, s_new, s_max;
  logic                    active;

  assign active  = IDX < int'(k_i);
  assign price_x = $signed({{(BAL_W + 1 - PRICE_W){1'b0}}, beat_i.price});

  // transaction update: buy after previous sell, then sell
  always_comb begin
    h_new = sat32($signed({beat_i.prev_sold[BAL_W-1], beat_i.prev_sold}) - price_x);
    h_max = (h_new > hold_q) ? h_new : hold_q;
    s_new = sat32($signed({h_max[BAL_W-1], h_max}) + price_x);
    s_max = (s_new > sold_q) ? s_new : sold_q;
  end

  // next state and outgoing beat
  always_comb begin
    hold_d = hold_q;
    sold_d = sold_q;
    beat_d = beat_i;
    if (beat_i.valid) begin
      if (beat_i.first) begin
        hold_d           = sat32(-price_x);
        sold_d           = '0;
        beat_d.prev_sold = '0;
      end else if (active) begin
        hold_d           = h_max;
        sold_d           = s_max;
        beat_d.prev_sold = s_max;
        if (s_max > 0 && s_max[PROFIT_W-1:0] > beat_i.best) begin
          beat_d.best = s_max[PROFIT_W-1:0];
        end
      end
    end
  end

  // balances and beat register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q <= '0;
      sold_q <= '0;
      beat_q <= '0;
    end else if (adv_i) begin
      hold_q <= hold_d;
      sold_q <= sold_d;
      beat_q <= beat_d;
    end
  end

  assign beat_o = beat_q;

endmodule

@@ hdl/k_transaction_max_profit.sv @@
`timescale 1ns / 1ps

// Best profit from at most K buy-sell transactions over a price stream. Prices
// enter one beat per clock unless the row is frozen and run down a row of
// MAX_CELLS transaction cells, each of which registers the beat, so the block
// sustains one item per cycle while not stalled. Cell j holds the hold and
// sold balances of transaction j; a beat with first set reloads every cell.
// The whole row freezes while a finished result is stalled at the output.
// max_transactions (byte address 0) is clamped to 1..MAX_CELLS, at most 31;
// the user must write it only while the row is empty (block does not enforce).
module k_transaction_max_profit #(
  parameter int MAX_CELLS  = 16,
  parameter int PRICE_BITS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [kmp_pkg::PRICE_W-1:0]    price_i,
  input  logic                           first_i,
  input  logic                           last_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [kmp_pkg::PROFIT_W-1:0]   profit_o,
  output logic                           final_res_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [1:0]                     paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  import kmp_pkg::*;

  localparam int PB = (PRICE_BITS < PRICE_W) ? PRICE_BITS : PRICE_W;
  localparam logic [PRICE_W-1:0] PRICE_MASK =
    PRICE_W'(({{PRICE_W{1'b0}}, 1'b1} << PB) - {{PRICE_W{1'b0}}, 1'b1});
  localparam logic [K_W-1:0] K_LIMIT =
    (MAX_CELLS < (1 << K_W)) ? K_W'(MAX_CELLS) : {K_W{1'b1}};

  logic [K_W-1:0] k_q, k_d;
  logic [K_W-1:0] k_eff;
  logic           adv;
  beat_t          chain [MAX_CELLS+1];

  // configuration register
  assign pready = 1'b1;

  always_comb begin
    k_d = k_q;
    if (psel && penable && pwrite && paddr == 2'b00) begin
      k_d = pwdata[K_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q <= K_W'(1);
    end else begin
      k_q <= k_d;
    end
  end

  assign prdata = (paddr == 2'b00) ? {{(32 - K_W){1'b0}}, k_q} : 32'd0;

  // clamp transaction count to the built row
  always_comb begin
    if (k_q == '0) begin
      k_eff = K_W'(1);
    end else if (k_q > K_LIMIT) begin
      k_eff = K_LIMIT;
    end else begin
      k_eff = k_q;
    end
  end

  // row advances unless the finished beat is held
  assign adv        = !(chain[MAX_CELLS].valid && out_stall_i);
  assign in_stall_o = !adv;

  // incoming beat: valid, first, last, price, prev_sold, best
  assign chain[0] = {in_valid_i, first_i, last_i, price_i & PRICE_MASK,
                     {BAL_W{1'b0}}, {PROFIT_W{1'b0}}};

  // row of transaction cells
  for (genvar j = 0; j < MAX_CELLS; j++) begin : g_cell
    kmp_cell #(
      .IDX (j)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .adv_i  (adv),
      .k_i    (k_eff),
      .beat_i (chain[j]),
      .beat_o (chain[j+1])
    );
  end

  // result from the end of the row
  assign out_valid_o = chain[MAX_CELLS].valid;
  assign profit_o    = chain[MAX_CELLS].best;
  assign final_res_o = chain[MAX_CELLS].last;

endmodule
